// File: sv/pdgm_pkg.sv
// Shared types, constants and the glyph table for the pixel despeckle unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pdgm_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 1024;
    localparam int LINE_AW    = $clog2(MAX_WIDTH);

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Configuration reset values
    localparam logic [5:0]  WIDTH_RESET  = 6'd30;
    localparam logic [10:0] HEIGHT_RESET = 11'd20;

    // Input request: one gray level
    typedef struct packed {
        logic [3:0] pixel_level;
    } pix_req_t;

    // Output request: one cleaned pixel
    typedef struct packed {
        logic [3:0] cleaned_level;
        logic [6:0] glyph_code;
        logic [9:0] out_row;
        logic [4:0] out_col;
        logic       frame_last;
    } res_req_t;

    // Configuration write request
    typedef struct packed {
        logic [1:0]  index;
        logic [10:0] data;
    } cfg_req_t;

    // Control from the top level into the filter datapath
    typedef struct packed {
        logic take;
        logic restart;
    } filt_ctl_t;

    // Control from the top level into the result queue
    typedef struct packed {
        logic       pop;
        logic [1:0] push_n;
    } queue_ctl_t;

    // ASCII glyph for a gray level; levels past the table map to '#'
    function automatic logic [6:0] glyph_of(input logic [3:0] level);
        logic [6:0] g;
        unique case (level)
            4'd0:    g = 7'h20;  // space
            4'd1:    g = 7'h2E;  // .
            4'd2:    g = 7'h27;  // '
            4'd3:    g = 7'h3A;  // :
            4'd4:    g = 7'h7E;  // ~
            4'd5:    g = 7'h2A;  // *
            4'd6:    g = 7'h3D;  // =
            4'd7:    g = 7'h26;  // &
            4'd8:    g = 7'h25;  // %
            default: g = 7'h23;  // #
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// File: sv/pdgm_if.sv
// Valid/ready channel interfaces for pixels, results and configuration.
// Depends on pdgm_pkg for the request payload types.
`timescale 1ns / 1ps
`default_nettype none

interface pdgm_pix_if;
    import pdgm_pkg::*;
    logic     valid;
    logic     ready;
    pix_req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pdgm_res_if;
    import pdgm_pkg::*;
    logic     valid;
    logic     ready;
    res_req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pdgm_cfg_if;
    import pdgm_pkg::*;
    logic     valid;
    logic     ready;
    cfg_req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/pdgm_filter.sv
// Despeckle datapath: line delays, raster counters and up to three results per pixel.
// Depends on pdgm_pkg for types, limits and the glyph table.
`timescale 1ns / 1ps
`default_nettype none

module pdgm_filter #(
    parameter int LEVEL_COUNT = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pdgm_pkg::filt_ctl_t        ctl,
    input  logic [3:0]                 pixel_level,
    input  logic [5:0]                 width_cfg,
    input  logic [10:0]                height_cfg,
    output pdgm_pkg::res_req_t [2:0]   res_new,
    output logic [1:0]                 n_new
);
    import pdgm_pkg::*;

    localparam logic [3:0] LEVEL_MAX = 4'(LEVEL_COUNT - 1);

    logic [3:0]         line_a_reg [MAX_WIDTH];
    logic [3:0]         line_b_reg [MAX_WIDTH];
    logic [3:0]         cur_m1_reg;
    logic [3:0]         cur_m2_reg;
    logic [3:0]         prev_c_reg;
    logic [3:0]         hold_reg;
    logic [4:0]         col_reg;
    logic [4:0]         col_next;
    logic [9:0]         row_reg;
    logic [9:0]         row_next;

    logic [3:0]         lvl;
    logic [5:0]         w_eff;
    logic [10:0]        h_eff;
    logic [4:0]         wm1;
    logic [9:0]         hm1;
    logic [LINE_AW-1:0] ins_a;
    logic [LINE_AW-1:0] ins_b;
    logic [3:0]         prev_cp1;
    logic [3:0]         older_c;
    logic               r_ge2;
    logic               c_ge1;
    logic               c_ge2;
    logic               c_end;
    logic               last_row;
    logic [3:0]         lvl_above;
    logic [3:0]         lvl_left;
    logic [3:0]         lvl_last;

    // Average rounded half up when the center beats every neighbor by more than one
    function automatic logic [3:0] despeckle(
        input logic [3:0]      ctr,
        input logic [3:0][3:0] nb,
        input logic [3:0]      use_nb
    );
        logic [6:0]  sum;
        logic [2:0]  n;
        logic        keep;
        logic [6:0]  x3;
        logic [12:0] p3;
        logic [6:0]  avg;
        sum  = '0;
        n    = '0;
        keep = 1'b0;
        x3   = '0;
        p3   = '0;
        for (int i = 0; i < 4; i++) begin
            if (use_nb[i]) begin
                n   = n + 3'd1;
                sum = sum + 7'(nb[i]);
                if ({1'b0, ctr} < ({1'b0, nb[i]} + 5'd2)) begin
                    keep = 1'b1;
                end
            end
        end
        unique case (n)
            3'd2:    avg = (sum + 7'd1) >> 1;
            3'd3:
            begin
                // (2s+3)/6 through a reciprocal; exact for the reachable sums
                x3  = (sum << 1) + 7'd3;
                p3  = 13'(x3) * 13'd43;
                avg = 7'(p3[12:8]);
            end
            3'd4:    avg = (sum + 7'd2) >> 2;
            default: avg = 7'(ctr);
        endcase
        return keep ? ctr : avg[3:0];
    endfunction

    // Saturate the incoming level
    assign lvl = (pixel_level > LEVEL_MAX) ? LEVEL_MAX : pixel_level;

    // Clamp the geometry registers
    always_comb
    begin
        if (width_cfg < 6'd2) begin
            w_eff = 6'd2;
        end else if (width_cfg > 6'(MAX_WIDTH)) begin
            w_eff = 6'(MAX_WIDTH);
        end else begin
            w_eff = width_cfg;
        end
        if (height_cfg < 11'd2) begin
            h_eff = 11'd2;
        end else if (height_cfg > 11'(MAX_HEIGHT)) begin
            h_eff = 11'(MAX_HEIGHT);
        end else begin
            h_eff = height_cfg;
        end
    end

    assign wm1   = 5'(w_eff - 6'd1);
    assign hm1   = 10'(h_eff - 11'd1);
    assign ins_a = LINE_AW'(w_eff - 6'd2);
    assign ins_b = LINE_AW'(wm1);

    // Line A delays the stream by width-1, line B delays the row-above tap by width
    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_line
        if (i == MAX_WIDTH - 1) begin : g_tail
            always_ff @(posedge clk)
            begin
                if (ctl.take) begin
                    line_a_reg[i] <= lvl;
                    line_b_reg[i] <= prev_c_reg;
                end
            end
        end else begin : g_body
            always_ff @(posedge clk)
            begin
                if (ctl.take) begin
                    line_a_reg[i] <= (LINE_AW'(i) == ins_a) ? lvl : line_a_reg[i+1];
                    line_b_reg[i] <= (LINE_AW'(i) == ins_b) ? prev_c_reg : line_b_reg[i+1];
                end
            end
        end
    end

    // Short taps: two pixels back in this row, row above at this column and one left
    always_ff @(posedge clk)
    begin
        if (ctl.take) begin
            cur_m1_reg <= lvl;
            cur_m2_reg <= cur_m1_reg;
            prev_c_reg <= line_a_reg[0];
            hold_reg   <= prev_c_reg;
        end
    end

    assign prev_cp1 = line_a_reg[0];
    assign older_c  = line_b_reg[0];

    // Advance the raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (ctl.restart) begin
            col_next = '0;
            row_next = '0;
        end else if (ctl.take) begin
            if (col_reg >= wm1) begin
                col_next = '0;
                row_next = (row_reg >= hm1) ? '0 : row_reg + 10'd1;
            end else begin
                col_next = col_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign r_ge2    = (row_reg >= 10'd2);
    assign c_ge1    = (col_reg != 5'd0);
    assign c_ge2    = (col_reg >= 5'd2);
    assign c_end    = (col_reg >= wm1);
    assign last_row = (row_reg >= hm1);

    // Judge the three candidate pixels
    assign lvl_above = despeckle(prev_c_reg,
                                 {prev_cp1, hold_reg, lvl, older_c},
                                 {(col_reg < wm1), c_ge1, 1'b1, r_ge2});
    assign lvl_left  = despeckle(cur_m1_reg,
                                 {4'd0, lvl, cur_m2_reg, hold_reg},
                                 {1'b0, 1'b1, c_ge2, 1'b1});
    assign lvl_last  = despeckle(lvl,
                                 {4'd0, 4'd0, cur_m1_reg, prev_c_reg},
                                 4'b0011);

    // Pack the results in emission order
    always_comb
    begin
        res_new[0].cleaned_level = lvl_above;
        res_new[0].glyph_code    = glyph_of(lvl_above);
        res_new[0].out_row       = row_reg - 10'd1;
        res_new[0].out_col       = col_reg;
        res_new[0].frame_last    = 1'b0;

        res_new[1].cleaned_level = lvl_left;
        res_new[1].glyph_code    = glyph_of(lvl_left);
        res_new[1].out_row       = row_reg;
        res_new[1].out_col       = col_reg - 5'd1;
        res_new[1].frame_last    = 1'b0;

        res_new[2].cleaned_level = lvl_last;
        res_new[2].glyph_code    = glyph_of(lvl_last);
        res_new[2].out_row       = row_reg;
        res_new[2].out_col       = col_reg;
        res_new[2].frame_last    = 1'b1;
    end

    // Count results: none in row 0, extra ones along the last row
    always_comb
    begin
        if (row_reg == 10'd0) begin
            n_new = 2'd0;
        end else if (last_row && c_end) begin
            n_new = 2'd3;
        end else if (last_row && c_ge1) begin
            n_new = 2'd2;
        end else begin
            n_new = 2'd1;
        end
    end

endmodule

`default_nettype wire

// File: sv/pdgm_result_queue.sv
// Four-entry shift queue that takes up to three results per cycle and gives one.
// Depends on pdgm_pkg for the result and control types.
`timescale 1ns / 1ps
`default_nettype none

module pdgm_result_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pdgm_pkg::queue_ctl_t       ctl,
    input  pdgm_pkg::res_req_t [2:0]   push_data,
    output pdgm_pkg::res_req_t         head,
    output logic [2:0]                 fill
);
    import pdgm_pkg::*;

    localparam int DEPTH = 4;

    res_req_t   q_reg  [DEPTH];
    res_req_t   q_next [DEPTH];
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [2:0] rem;

    assign rem = cnt_reg - {2'b00, ctl.pop};

    // Shift down on a pop, then append new results behind the survivors
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++) begin
            logic [2:0] k;
            k = 3'(i) - rem;
            q_next[i] = (ctl.pop && (i < DEPTH - 1)) ? q_reg[(i < DEPTH - 1) ? i + 1 : i]
                                                     : q_reg[i];
            if ((3'(i) >= rem) && (k < {1'b0, ctl.push_n})) begin
                q_next[i] = push_data[k[1:0]];
            end
        end
    end

    assign cnt_next = rem + {1'b0, ctl.push_n};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign head = q_reg[0];
    assign fill = cnt_reg;

endmodule

`default_nettype wire

// File: sv/pixel_despeckle_and_glyph_map_unit.sv
// Path: a pixel's results enter the result queue when the pixel is accepted.
// Throughput: one pixel per cycle while the result queue has room; row 0 yields
// nothing, other rows one result per pixel, the last row two per pixel and the final
// pixel three, so on the last row the single result port sets the pace.
// Reset: counters return to row 0, column 0, width 30, height 20, queue empties;
// the line delays start unknown and are filled by row 0 of each frame.
`timescale 1ns / 1ps
`default_nettype none

module pixel_despeckle_and_glyph_map_unit #(
    parameter int LEVEL_COUNT = 10
) (
    input  logic      clk,
    input  logic      rst_n,
    pdgm_pix_if.sink  pix,
    pdgm_res_if.source res,
    pdgm_cfg_if.sink  cfg
);
    import pdgm_pkg::*;

    logic [5:0]     width_reg;
    logic [10:0]    height_reg;
    logic           cfg_take;
    logic           restart;
    logic           pop;
    logic [2:0]     fill;
    res_req_t [2:0] res_new;
    logic [1:0]     n_new;
    filt_ctl_t      filt_ctl;
    queue_ctl_t     q_ctl;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_take  = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_take) begin
            unique case (cfg.payload.index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg.payload.data[5:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg.payload.data;
                default:          ;
            endcase
        end
    end

    // Any write to a known register restarts the frame
    assign restart = cfg_take && ((cfg.payload.index == REG_IMAGE_WIDTH) ||
                                  (cfg.payload.index == REG_IMAGE_HEIGHT));

    // Take a pixel when the queue has room for three results after this pop
    assign pop       = res.valid && res.ready;
    assign pix.ready = (fill <= 3'd1) || ((fill == 3'd2) && pop);

    assign filt_ctl.take    = pix.valid && pix.ready;
    assign filt_ctl.restart = restart;

    pdgm_filter #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_filter (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (filt_ctl),
        .pixel_level (pix.payload.pixel_level),
        .width_cfg   (width_reg),
        .height_cfg  (height_reg),
        .res_new     (res_new),
        .n_new       (n_new)
    );

    assign q_ctl.pop    = pop;
    assign q_ctl.push_n = filt_ctl.take ? n_new : 2'd0;

    pdgm_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (q_ctl),
        .push_data (res_new),
        .head      (res.payload),
        .fill      (fill)
    );

    assign res.valid = (fill != 3'd0);

endmodule

`default_nettype wire
